### hdl/ehlo_capability_line_parser_defines.svh
// Assertion macros for the parser RTL
`ifndef EHLO_CAPABILITY_LINE_PARSER_DEFINES_SVH
`define EHLO_CAPABILITY_LINE_PARSER_DEFINES_SVH

// same-cycle implication
`define ECPL_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ECPL_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ecpl_pkg.sv
`default_nettype none

package ecpl_pkg;

	localparam int unsigned SIZE_BITS     = 32;
	localparam int unsigned OUT_SIZE_BITS = 32;
	localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_TWO  = 8'h32;
	localparam logic [7:0] CH_FIVE = 8'h35;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LC_A = 8'h61;
	localparam logic [7:0] CH_LC_Z = 8'h7A;

	localparam logic [1:0] KW_STARTTLS   = 2'd0;
	localparam logic [1:0] KW_PIPELINING = 2'd1;
	localparam logic [1:0] KW_SIZE       = 2'd2;
	localparam logic [1:0] KW_AUTH       = 2'd3;

	localparam logic [3:0][79:0] KW_TXT = {
		{"AUTH", 48'h0},
		{"SIZE", 48'h0},
		"PIPELINING",
		{"STARTTLS", 16'h0}
	};
	localparam logic [3:0][3:0] KW_LEN = {4'd4, 4'd4, 4'd10, 4'd8};
	localparam logic [3:0] POS_MAX = 4'd15;

	localparam logic [1:0][39:0] MECH_TXT = {"LOGIN", "PLAIN"};
	localparam logic [2:0] MECH_LEN = 3'd5;

	typedef enum logic [2:0] {
		PH_CODE    = 3'd0,
		PH_SPACES  = 3'd1,
		PH_KEYWORD = 3'd2,
		PH_SIZE    = 3'd3,
		PH_AUTH    = 3'd4,
		PH_DEAD    = 3'd5
	} phase_t;

	typedef struct packed {
		logic       op;
		logic [7:0] byte_value;
		logic       last_byte;
	} req_t;

	typedef struct packed {
		logic                     has_starttls;
		logic                     has_pipelining;
		logic                     has_size;
		logic                     has_auth;
		logic                     auth_plain;
		logic                     auth_login;
		logic [OUT_SIZE_BITS-1:0] max_msg_size;
		logic                     size_clipped;
	} rsp_t;

	typedef struct packed {
		phase_t               line_phase;
		logic [3:0]           char_position;
		logic [3:0]           keyword_candidates;
		logic                 pending_terminator;
		logic [3:0]           capability_flags;
		logic [1:0]           mechanism_flags;
		logic [SIZE_BITS-1:0] stored_size;
		logic                 stored_clipped;
		logic [SIZE_BITS-1:0] size_accumulator;
		logic                 accumulator_clipped;
		logic                 digits_seen;
		logic [1:0]           token_candidates;
		logic [2:0]           token_position;
	} line_state_t;

	localparam line_state_t STATE_RESET = '{
		line_phase:          PH_CODE,
		char_position:       4'd0,
		keyword_candidates:  4'hF,
		pending_terminator:  1'b0,
		capability_flags:    4'h0,
		mechanism_flags:     2'b00,
		stored_size:         '0,
		stored_clipped:      1'b0,
		size_accumulator:    '0,
		accumulator_clipped: 1'b0,
		digits_seen:         1'b0,
		token_candidates:    2'b11,
		token_position:      3'd0
	};

	function automatic logic [7:0] kw_char(logic [1:0] k, logic [3:0] pos);
		logic [79:0] t;
		t = KW_TXT[k] << {pos, 3'b000};
		return t[79:72];
	endfunction

	function automatic logic [7:0] mech_char(logic m, logic [2:0] pos);
		logic [39:0] t;
		t = MECH_TXT[m] << {pos, 3'b000};
		return t[39:32];
	endfunction

endpackage

`default_nettype wire

### hdl/ecpl_core.sv
`default_nettype none

module ecpl_core import ecpl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic advance,
	input  wire req_t item,
	output logic      res_valid,
	output rsp_t      res
);

	line_state_t state_q;
	line_state_t state_d;
	logic        fire;
	logic        crlf;

	function automatic logic [7:0] upcase(logic [7:0] c);
		return (c >= CH_LC_A && c <= CH_LC_Z) ? c - 8'h20 : c;
	endfunction

	function automatic line_state_t keyword_done(line_state_t s_in, logic [1:0] k,
			logic [7:0] sep);
		line_state_t s;
		s = s_in;
		s.capability_flags[k] = 1'b1;
		s.line_phase = PH_DEAD;
		if (k == KW_SIZE && sep == CH_SP) begin
			s.line_phase = PH_SIZE;
			s.size_accumulator = '0;
			s.accumulator_clipped = 1'b0;
			s.digits_seen = 1'b0;
		end else if (k == KW_AUTH && sep != CH_NUL) begin
			s.line_phase = PH_AUTH;
			s.token_candidates = 2'b11;
			s.token_position = 3'd0;
		end
		return s;
	endfunction

	function automatic line_state_t token_end(line_state_t s_in);
		line_state_t s;
		s = s_in;
		if (s.token_position == MECH_LEN) begin
			s.mechanism_flags = s.mechanism_flags | s.token_candidates;
		end
		s.token_candidates = 2'b11;
		s.token_position = 3'd0;
		return s;
	endfunction

	function automatic line_state_t size_store(line_state_t s_in);
		line_state_t s;
		s = s_in;
		if (s.digits_seen) begin
			s.stored_size = s.size_accumulator;
			s.stored_clipped = s.accumulator_clipped;
		end
		return s;
	endfunction

	function automatic line_state_t feed(line_state_t s_in, logic [7:0] c);
		line_state_t          s;
		logic [7:0]           uc;
		logic                 done;
		logic [3:0]           digit;
		logic [SIZE_BITS+3:0] wide;
		int unsigned          k;
		int unsigned          m;
		s = s_in;
		uc = upcase(c);
		done = 1'b0;
		digit = 4'(c - CH_ZERO);
		wide = '0;
		if (s.line_phase == PH_SPACES && c != CH_SP) begin
			s.line_phase = PH_KEYWORD;
			s.char_position = 4'd0;
			s.keyword_candidates = 4'hF;
		end
		unique case (s.line_phase)
			PH_CODE: begin
				if ((s.char_position == 4'd0 && c != CH_TWO) ||
						(s.char_position == 4'd1 && c != CH_FIVE) ||
						(s.char_position == 4'd2 && c != CH_ZERO) ||
						(s.char_position == 4'd3 && c != CH_SP && c != CH_DASH)) begin
					s.line_phase = PH_DEAD;
				end else if (s.char_position == 4'd3) begin
					s.line_phase = PH_SPACES;
					s.char_position = 4'd0;
				end else begin
					s.char_position = s.char_position + 4'd1;
				end
			end
			PH_SPACES: begin
			end
			PH_KEYWORD: begin
				for (k = 0; k < 4; k++) begin
					if (!done && s.keyword_candidates[2'(k)]) begin
						if (s.char_position < KW_LEN[2'(k)]) begin
							if (uc != kw_char(2'(k), s.char_position)) begin
								s.keyword_candidates[2'(k)] = 1'b0;
							end
						end else if (s.char_position == KW_LEN[2'(k)] &&
								(c == CH_SP || c == CH_EQ)) begin
							s = keyword_done(s, 2'(k), c);
							done = 1'b1;
						end else begin
							s.keyword_candidates[2'(k)] = 1'b0;
						end
					end
				end
				if (!done) begin
					if (s.char_position < POS_MAX) begin
						s.char_position = s.char_position + 4'd1;
					end
					if (s.keyword_candidates == 4'h0) begin
						s.line_phase = PH_DEAD;
					end
				end
			end
			PH_SIZE: begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					wide = ({4'b0000, s.size_accumulator} << 3) +
						({4'b0000, s.size_accumulator} << 1) + (SIZE_BITS+4)'(digit);
					if (wide > {4'b0000, SIZE_MAX}) begin
						s.size_accumulator = SIZE_MAX;
						s.accumulator_clipped = 1'b1;
					end else begin
						s.size_accumulator = wide[SIZE_BITS-1:0];
					end
					s.digits_seen = 1'b1;
				end else if (c == CH_SP && !s.digits_seen) begin
					s.digits_seen = 1'b0;
				end else begin
					s = size_store(s);
					s.line_phase = PH_DEAD;
				end
			end
			PH_AUTH: begin
				if (c == CH_SP || c == CH_EQ) begin
					s = token_end(s);
				end else if (s.token_position < MECH_LEN) begin
					for (m = 0; m < 2; m++) begin
						if (uc != mech_char(1'(m), s.token_position)) begin
							s.token_candidates[1'(m)] = 1'b0;
						end
					end
					s.token_position = s.token_position + 3'd1;
				end else begin
					s.token_candidates = 2'b00;
				end
			end
			default: begin
			end
		endcase
		return s;
	endfunction

	function automatic line_state_t finish_line(line_state_t s_in);
		line_state_t s;
		logic        done;
		int unsigned k;
		s = s_in;
		done = 1'b0;
		if (s.line_phase == PH_KEYWORD) begin
			for (k = 0; k < 4; k++) begin
				if (!done && s.keyword_candidates[2'(k)] &&
						s.char_position == KW_LEN[2'(k)]) begin
					s = keyword_done(s, 2'(k), CH_NUL);
					done = 1'b1;
				end
			end
		end else if (s.line_phase == PH_SIZE) begin
			s = size_store(s);
		end else if (s.line_phase == PH_AUTH) begin
			s = token_end(s);
		end
		s.line_phase = STATE_RESET.line_phase;
		s.char_position = STATE_RESET.char_position;
		s.keyword_candidates = STATE_RESET.keyword_candidates;
		s.pending_terminator = STATE_RESET.pending_terminator;
		s.size_accumulator = STATE_RESET.size_accumulator;
		s.accumulator_clipped = STATE_RESET.accumulator_clipped;
		s.digits_seen = STATE_RESET.digits_seen;
		s.token_candidates = STATE_RESET.token_candidates;
		s.token_position = STATE_RESET.token_position;
		return s;
	endfunction

	always_comb begin
		state_d = state_q;
		fire = 1'b0;
		crlf = (item.byte_value == CH_CR) || (item.byte_value == CH_LF);
		if (item.op) begin
			state_d.capability_flags = 4'h0;
			state_d.mechanism_flags = 2'b00;
			state_d.stored_size = '0;
			state_d.stored_clipped = 1'b0;
		end else if (crlf && !item.last_byte) begin
			state_d.pending_terminator = 1'b1;
		end else begin
			if (!crlf) begin
				if (state_d.pending_terminator) begin
					state_d = feed(state_d, CH_CR);
					state_d.pending_terminator = 1'b0;
				end
				state_d = feed(state_d, item.byte_value);
			end
			if (item.last_byte) begin
				state_d = finish_line(state_d);
				fire = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	assign res_valid = fire;

	always_comb begin
		res.has_starttls   = state_d.capability_flags[KW_STARTTLS];
		res.has_pipelining = state_d.capability_flags[KW_PIPELINING];
		res.has_size       = state_d.capability_flags[KW_SIZE];
		res.has_auth       = state_d.capability_flags[KW_AUTH];
		res.auth_plain     = state_d.mechanism_flags[0];
		res.auth_login     = state_d.mechanism_flags[1];
		res.max_msg_size   = OUT_SIZE_BITS'(state_d.stored_size);
		res.size_clipped   = state_d.stored_clipped;
	end

endmodule

`default_nettype wire

### hdl/ehlo_capability_line_parser.sv
// Path: an accepted item is registered in the input register; when the output register is free
// the core advances on it, and a line-end result is loaded into the output register to be taken.
// Throughput: one item per cycle; while a finished result waits to be taken one more
// item is held in the input register, and the input stalls after that.
// Reset: capabilities, stored size and line state clear at once; no clearing pass.
`default_nettype none
`include "ehlo_capability_line_parser_defines.svh"

module ehlo_capability_line_parser import ecpl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	logic valid_s1;
	req_t item_s1;
	logic out_free;
	logic advance;
	logic res_valid;
	rsp_t res;
	logic rsp_valid_q;
	rsp_t rsp_q;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign advance   = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req;
		end
	end

	ecpl_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ECPL_ASSERT_NXT(a_s1_hold, valid_s1 && !out_free, valid_s1 && $stable(item_s1), "held item lost")
	`ECPL_ASSERT_NXT(a_line_end, advance && !item_s1.op && item_s1.last_byte, rsp_valid_q, "no result at line end")
	`ECPL_ASSERT_NXT(a_no_spurious, advance && (item_s1.op || !item_s1.last_byte), !rsp_valid_q, "result without line end")
	`ECPL_ASSERT_IMP(a_clip_max, rsp_valid_q && rsp_q.size_clipped, rsp_q.max_msg_size == OUT_SIZE_BITS'(SIZE_MAX), "clipped size not saturated")

endmodule

`default_nettype wire
